### sv/lrut_pkg.sv
// ----------------------------------------------------------------------------
// lrut_pkg: shared types and codes for the LRU page tracker table
// Entry layout, operation and status codes, controller states.
// ----------------------------------------------------------------------------
package lrut_pkg;

    localparam int DEF_ENTRIES = 64;

    localparam int PAGE_W   = 32;
    localparam int TIME_W   = 48;
    localparam int ORDER_W  = 32;
    localparam int OPCODE_W = 3;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 7;

    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 96;

    localparam logic [OPCODE_W-1:0] OP_INSERT = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_TOUCH  = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_REMOVE = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_EVICT  = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_LOOKUP = 3'd4;
    localparam logic [OPCODE_W-1:0] OP_COUNT  = 3'd5;

    localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_EMPTY     = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_DUPLICATE = 3'd4;

    // One table entry as held in the RAM word.
    typedef struct packed {
        logic               valid;
        logic [ORDER_W-1:0] order;
        logic [TIME_W-1:0]  time_stamp;
        logic [PAGE_W-1:0]  page;
    } entry_t;

    // Summary gathered over one pass across the table.
    typedef struct packed {
        logic               found;
        logic [TIME_W-1:0]  found_time;
        logic [ORDER_W-1:0] found_order;
        logic               free_found;
        logic               min_found;
        logic [PAGE_W-1:0]  min_page;
        logic [TIME_W-1:0]  min_time;
    } scan_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_WRITE,
        S_RESP
    } state_t;

endpackage

### sv/lru_page_tracker_table.sv
// ----------------------------------------------------------------------------
// lru_page_tracker_table: LRU replacement table with last-use timestamps
// Holds up to ENTRIES resident pages in one RAM and serves insert, touch,
// remove, evict-oldest, lookup and count requests one at a time.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Signals                      Carries
//  -------  ---------  ---------------------------  ------------------------
//  s_*      in         s_tvalid s_tready s_tdata    one operation request
//  m_*      out        m_tvalid m_tready m_tdata    one result per request
//
// Insert, touch, remove, evict and lookup each make one pass over the whole
// table through the single RAM read port, one entry per cycle. Count and
// the unused codes skip the pass. After reset a clearing pass writes every
// entry invalid; no request is accepted until it has finished.
// A result that is not taken stalls the next request only when that
// request's own result is ready; the request itself is still accepted.
//
module lru_page_tracker_table #(
    parameter int ENTRIES = lrut_pkg::DEF_ENTRIES
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // s_tdata, from bit 0: opcode[2:0], page[34:3], time_stamp[82:35], zero pad
    input  logic [lrut_pkg::IN_DATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // m_tdata, from bit 0: status[2:0], result_page[34:3], result_time[82:35],
    // entry_count[89:83], zero pad
    output logic [lrut_pkg::OUT_DATA_W-1:0] m_tdata
);

    import lrut_pkg::*;

    localparam int AW = $clog2(ENTRIES);

    logic          rd_en;
    logic [AW-1:0] rd_addr;
    entry_t        rd_data;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    entry_t        wr_data;

    logic              scan_start;
    logic [PAGE_W-1:0] key_page;
    scan_t             scan;
    logic [AW-1:0]     found_slot;
    logic [AW-1:0]     free_slot;
    logic [AW-1:0]     min_slot;

    // Every entry (valid flag, order stamp, time and page) lives in one word,
    // so a write-back touches exactly one address. Reads and the write-back
    // never overlap: the write happens only after the pass has ended.
    lrut_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (ENTRIES)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // The evaluator sees each entry in the cycle after its address was issued
    // and keeps the first match, the lowest free slot and the oldest entry.
    lrut_scan #(
        .ENTRIES (ENTRIES)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (scan_start),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .key_page   (key_page),
        .result     (scan),
        .found_slot (found_slot),
        .free_slot  (free_slot),
        .min_slot   (min_slot)
    );

    // The sequencer owns the clearing pass, the pass counter, the order
    // stamp counter, the entry count and the output register.
    lrut_ctrl #(
        .ENTRIES (ENTRIES)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .scan_start (scan_start),
        .key_page   (key_page),
        .scan       (scan),
        .found_slot (found_slot),
        .free_slot  (free_slot),
        .min_slot   (min_slot)
    );

endmodule

### sv/lrut_ram.sv
// ----------------------------------------------------------------------------
// lrut_ram: generic single-port-write, single-port-read RAM
// Synchronous write, registered read.
// ----------------------------------------------------------------------------
module lrut_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/lrut_scan.sv
// ----------------------------------------------------------------------------
// lrut_scan: table pass evaluator
// Takes the entries read back one per cycle and keeps the first matching
// page, the lowest free slot and the oldest valid entry.
// ----------------------------------------------------------------------------
module lrut_scan #(
    parameter int ENTRIES = lrut_pkg::DEF_ENTRIES
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic                       rd_en,
    input  logic [$clog2(ENTRIES)-1:0] rd_addr,
    input  lrut_pkg::entry_t           rd_data,
    input  logic [lrut_pkg::PAGE_W-1:0] key_page,
    output lrut_pkg::scan_t            result,
    output logic [$clog2(ENTRIES)-1:0] found_slot,
    output logic [$clog2(ENTRIES)-1:0] free_slot,
    output logic [$clog2(ENTRIES)-1:0] min_slot
);

    import lrut_pkg::*;

    localparam int AW = $clog2(ENTRIES);

    logic               chk_valid_reg;
    logic [AW-1:0]      chk_idx_reg;

    logic               found_reg;
    logic [AW-1:0]      found_slot_reg;
    logic [TIME_W-1:0]  found_time_reg;
    logic [ORDER_W-1:0] found_order_reg;
    logic               free_found_reg;
    logic [AW-1:0]      free_slot_reg;
    logic               min_found_reg;
    logic [AW-1:0]      min_slot_reg;
    logic [PAGE_W-1:0]  min_page_reg;
    logic [TIME_W-1:0]  min_time_reg;
    logic [ORDER_W-1:0] min_order_reg;

    logic take_match;
    logic take_free;
    logic take_min;

    // Strictly older wins, so an equal time and order keeps the lower slot.
    always_comb
    begin
        take_match = chk_valid_reg && rd_data.valid && (rd_data.page == key_page)
                     && !found_reg;
        take_free  = chk_valid_reg && !rd_data.valid && !free_found_reg;
        take_min   = chk_valid_reg && rd_data.valid &&
                     (!min_found_reg || (rd_data.time_stamp < min_time_reg) ||
                      ((rd_data.time_stamp == min_time_reg) &&
                       (rd_data.order < min_order_reg)));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chk_valid_reg  <= 1'b0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            min_found_reg  <= 1'b0;
        end
        else
        begin
            chk_valid_reg <= rd_en;
            if (start)
            begin
                found_reg      <= 1'b0;
                free_found_reg <= 1'b0;
                min_found_reg  <= 1'b0;
            end
            else
            begin
                if (take_match)
                begin
                    found_reg <= 1'b1;
                end
                if (take_free)
                begin
                    free_found_reg <= 1'b1;
                end
                if (take_min)
                begin
                    min_found_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        chk_idx_reg <= rd_addr;
        if (take_match)
        begin
            found_slot_reg  <= chk_idx_reg;
            found_time_reg  <= rd_data.time_stamp;
            found_order_reg <= rd_data.order;
        end
        if (take_free)
        begin
            free_slot_reg <= chk_idx_reg;
        end
        if (take_min)
        begin
            min_slot_reg  <= chk_idx_reg;
            min_page_reg  <= rd_data.page;
            min_time_reg  <= rd_data.time_stamp;
            min_order_reg <= rd_data.order;
        end
    end

    always_comb
    begin
        result.found       = found_reg;
        result.found_time  = found_time_reg;
        result.found_order = found_order_reg;
        result.free_found  = free_found_reg;
        result.min_found   = min_found_reg;
        result.min_page    = min_page_reg;
        result.min_time    = min_time_reg;
    end

    assign found_slot = found_slot_reg;
    assign free_slot  = free_slot_reg;
    assign min_slot   = min_slot_reg;

endmodule

### sv/lrut_ctrl.sv
// ----------------------------------------------------------------------------
// lrut_ctrl: sequencer for the LRU page tracker table
// Clears the RAM after reset, drives the table pass, writes back the one
// modified entry, if any, and holds the result in the output register.
// ----------------------------------------------------------------------------
module lrut_ctrl #(
    parameter int ENTRIES = lrut_pkg::DEF_ENTRIES
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [lrut_pkg::IN_DATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [lrut_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic                            rd_en,
    output logic [$clog2(ENTRIES)-1:0]      rd_addr,
    output logic                            wr_en,
    output logic [$clog2(ENTRIES)-1:0]      wr_addr,
    output lrut_pkg::entry_t                wr_data,
    output logic                            scan_start,
    output logic [lrut_pkg::PAGE_W-1:0]     key_page,
    input  lrut_pkg::scan_t                 scan,
    input  logic [$clog2(ENTRIES)-1:0]      found_slot,
    input  logic [$clog2(ENTRIES)-1:0]      free_slot,
    input  logic [$clog2(ENTRIES)-1:0]      min_slot
);

    import lrut_pkg::*;

    localparam int AW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    state_t state_reg, state_next;

    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [ORDER_W-1:0]  order_reg, order_next;
    logic [OPCODE_W-1:0] op_reg, op_next;
    logic [PAGE_W-1:0]   page_reg, page_next;
    logic [TIME_W-1:0]   time_reg, time_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [PAGE_W-1:0]   res_page_reg, res_page_next;
    logic [TIME_W-1:0]   res_time_reg, res_time_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic in_accept;
    logic in_scans;
    logic out_free;

    assign in_accept = s_tready && s_tvalid;
    assign in_scans  = (s_tdata[OPCODE_W-1:0] <= OP_LOOKUP);
    assign out_free  = !m_tvalid_reg || m_tready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (cnt_reg == CW'(ENTRIES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = in_scans ? S_SCAN : S_WRITE;
                end
            end
            S_SCAN:
            begin
                if (cnt_reg == CW'(ENTRIES))
                begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // Outputs and datapath
    always_comb
    begin
        s_tready        = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = cnt_reg[AW-1:0];
        wr_en           = 1'b0;
        wr_addr         = cnt_reg[AW-1:0];
        wr_data         = '0;
        scan_start      = 1'b0;
        cnt_next        = cnt_reg;
        count_next      = count_reg;
        order_next      = order_reg;
        op_next         = op_reg;
        page_next       = page_reg;
        time_next       = time_reg;
        res_status_next = res_status_reg;
        res_page_next   = res_page_reg;
        res_time_next   = res_time_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                wr_en    = 1'b1;
                cnt_next = cnt_reg + 1'b1;
            end
            S_IDLE:
            begin
                s_tready   = 1'b1;
                cnt_next   = '0;
                scan_start = in_accept;
                if (in_accept)
                begin
                    op_next   = s_tdata[OPCODE_W-1:0];
                    page_next = s_tdata[OPCODE_W +: PAGE_W];
                    time_next = s_tdata[OPCODE_W + PAGE_W +: TIME_W];
                end
            end
            S_SCAN:
            begin
                if (cnt_reg != CW'(ENTRIES))
                begin
                    rd_en    = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_WRITE:
            begin
                res_status_next = STAT_OK;
                res_page_next   = '0;
                res_time_next   = '0;
                unique case (op_reg)
                    OP_INSERT:
                    begin
                        if (scan.found)
                        begin
                            res_status_next = STAT_DUPLICATE;
                        end
                        else if (!scan.free_found)
                        begin
                            res_status_next = STAT_FULL;
                        end
                        else
                        begin
                            wr_en              = 1'b1;
                            wr_addr            = free_slot;
                            wr_data.valid      = 1'b1;
                            wr_data.order      = order_reg;
                            wr_data.time_stamp = time_reg;
                            wr_data.page       = page_reg;
                            order_next         = order_reg + 1'b1;
                            count_next         = count_reg + 1'b1;
                        end
                    end
                    OP_TOUCH:
                    begin
                        if (!scan.found)
                        begin
                            res_status_next = STAT_NOT_FOUND;
                        end
                        else
                        begin
                            // A touch with the same time keeps the entry's order stamp.
                            wr_en              = 1'b1;
                            wr_addr            = found_slot;
                            wr_data.valid      = 1'b1;
                            wr_data.time_stamp = time_reg;
                            wr_data.page       = page_reg;
                            if (scan.found_time != time_reg)
                            begin
                                wr_data.order = order_reg;
                                order_next    = order_reg + 1'b1;
                            end
                            else
                            begin
                                wr_data.order = scan.found_order;
                            end
                        end
                    end
                    OP_REMOVE:
                    begin
                        if (!scan.found)
                        begin
                            res_status_next = STAT_NOT_FOUND;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            wr_addr    = found_slot;
                            count_next = count_reg - 1'b1;
                        end
                    end
                    OP_EVICT:
                    begin
                        if (!scan.min_found)
                        begin
                            res_status_next = STAT_EMPTY;
                        end
                        else
                        begin
                            wr_en         = 1'b1;
                            wr_addr       = min_slot;
                            count_next    = count_reg - 1'b1;
                            res_page_next = scan.min_page;
                            res_time_next = scan.min_time;
                        end
                    end
                    OP_LOOKUP:
                    begin
                        if (!scan.found)
                        begin
                            res_status_next = STAT_NOT_FOUND;
                        end
                        else
                        begin
                            res_time_next = scan.found_time;
                        end
                    end
                    default:
                    begin
                        // Count and the unused codes change nothing.
                    end
                endcase
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {6'b0, COUNT_W'(count_reg), res_time_reg,
                                     res_page_reg, res_status_reg};
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            cnt_reg      <= '0;
            count_reg    <= '0;
            order_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            count_reg    <= count_next;
            order_reg    <= order_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        page_reg       <= page_next;
        time_reg       <= time_next;
        res_status_reg <= res_status_next;
        res_page_reg   <= res_page_next;
        res_time_reg   <= res_time_next;
        m_tdata_reg    <= m_tdata_next;
    end

    assign key_page = page_reg;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

### tb/lru_page_tracker_table_test.sv
// ----------------------------------------------------------------------------
// lru_page_tracker_table_test: self-checking bench for the LRU page tracker
// Drives insert, touch, remove, evict, lookup and count requests through the
// request stream, predicts every result from a private copy of the table and
// compares each returned result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module lru_page_tracker_table_test;

    import lrut_pkg::*;

    localparam int ENTRIES = 64;

    // Opcodes 6 and 7 have no function; the block must answer them with OK.
    localparam logic [OPCODE_W-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [OPCODE_W-1:0] OP_SPARE_HI = 3'd7;

    localparam int POOL_SIZE  = 72;
    localparam int RAND_ITEMS = 700;
    localparam int HOLD_START = 8000;
    localparam int HOLD_LEN   = 1000;
    localparam int TAIL_WAIT  = 80;
    localparam int CYCLE_CAP  = 600000;

    typedef struct {
        logic [OPCODE_W-1:0] opcode;
        logic [PAGE_W-1:0]   page;
        logic [TIME_W-1:0]   stamp;
        bit                  settle;   // hold this request back until all results are in
    } page_req_t;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [PAGE_W-1:0]   page;
        logic [TIME_W-1:0]   stamp;
        logic [COUNT_W-1:0]  count;
    } page_reply_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    page_req_t   pending_reqs[$];
    page_reply_t replies_due[$];
    page_req_t   req_on_bus;
    int          mismatches = 0;

    // Private copy of the page table used for prediction.
    bit                 trk_valid[ENTRIES];
    logic [PAGE_W-1:0]  trk_page[ENTRIES];
    logic [TIME_W-1:0]  trk_stamp[ENTRIES];
    logic [ORDER_W-1:0] trk_order[ENTRIES];
    logic [ORDER_W-1:0] trk_next_order = '0;
    int                 trk_live = 0;

    lru_page_tracker_table #(
        .ENTRIES (ENTRIES)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Slot holding a resident page, or -1 when the page is absent.
    function automatic int resident_slot(logic [PAGE_W-1:0] pg);
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (trk_valid[i] && trk_page[i] == pg)
                return i;
        end
        return -1;
    endfunction

    // Applies one request to the private table and returns the result that
    // the block should give for it.
    function automatic page_reply_t track_page_op(page_req_t rq);
        page_reply_t rp;
        int          slot;
        rp.status = STAT_OK;
        rp.page   = '0;
        rp.stamp  = '0;
        slot      = -1;
        case (rq.opcode)
            OP_INSERT:
            begin
                if (resident_slot(rq.page) >= 0)
                    rp.status = STAT_DUPLICATE;
                else
                begin
                    // A new page always takes the lowest free slot.
                    for (int i = ENTRIES - 1; i >= 0; i--)
                    begin
                        if (!trk_valid[i])
                            slot = i;
                    end
                    if (slot < 0)
                        rp.status = STAT_FULL;
                    else
                    begin
                        trk_valid[slot] = 1'b1;
                        trk_page[slot]  = rq.page;
                        trk_stamp[slot] = rq.stamp;
                        trk_order[slot] = trk_next_order;
                        trk_next_order  = trk_next_order + 1'b1;
                        trk_live++;
                    end
                end
            end
            OP_TOUCH:
            begin
                slot = resident_slot(rq.page);
                if (slot < 0)
                    rp.status = STAT_NOT_FOUND;
                else if (trk_stamp[slot] != rq.stamp)
                begin
                    // Touching with the same time keeps the place in the tie order.
                    trk_stamp[slot] = rq.stamp;
                    trk_order[slot] = trk_next_order;
                    trk_next_order  = trk_next_order + 1'b1;
                end
            end
            OP_REMOVE:
            begin
                slot = resident_slot(rq.page);
                if (slot < 0)
                    rp.status = STAT_NOT_FOUND;
                else
                begin
                    trk_valid[slot] = 1'b0;
                    trk_live--;
                end
            end
            OP_EVICT:
            begin
                // Oldest time wins; among equal times the smallest order stamp,
                // and among equal stamps the lowest slot.
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (trk_valid[i] && (slot < 0 || trk_stamp[i] < trk_stamp[slot] ||
                        (trk_stamp[i] == trk_stamp[slot] && trk_order[i] < trk_order[slot])))
                        slot = i;
                end
                if (slot < 0)
                    rp.status = STAT_EMPTY;
                else
                begin
                    rp.page         = trk_page[slot];
                    rp.stamp        = trk_stamp[slot];
                    trk_valid[slot] = 1'b0;
                    trk_live--;
                end
            end
            OP_LOOKUP:
            begin
                slot = resident_slot(rq.page);
                if (slot < 0)
                    rp.status = STAT_NOT_FOUND;
                else
                    rp.stamp = trk_stamp[slot];
            end
            default:
            begin
                // Count and the spare opcodes leave the table alone.
            end
        endcase
        rp.count = COUNT_W'(trk_live);
        return rp;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    function automatic void queue_request(logic [OPCODE_W-1:0] op, logic [PAGE_W-1:0] pg,
                                          logic [TIME_W-1:0] ts, bit settle = 1'b0);
        page_req_t rq;
        rq.opcode = op;
        rq.page   = pg;
        rq.stamp  = ts;
        rq.settle = settle;
        pending_reqs.insert(pending_reqs.size(), rq);
    endfunction

    initial
    begin : stimulus
        logic [PAGE_W-1:0]   page_pool[POOL_SIZE];
        logic [PAGE_W-1:0]   pg;
        logic [TIME_W-1:0]   ts;
        logic [TIME_W-1:0]   clock_now;
        logic [OPCODE_W-1:0] op;
        int                  made;
        int                  phase_no;
        int                  phase_kind;
        int                  phase_left;
        int                  walk_idx;
        int                  pick;
        bit                  settle;

        for (int i = 0; i < ENTRIES; i++)
            trk_valid[i] = 1'b0;

        // Directed part: empty-table behaviour, absent pages, spare opcodes,
        // field extremes, duplicates, timestamp ties and a same-time touch.
        queue_request(OP_EVICT,    32'h0000_1234, '0);
        queue_request(OP_LOOKUP,   32'h0000_1234, '0);
        queue_request(OP_TOUCH,    32'h0000_1234, 48'h1);
        queue_request(OP_REMOVE,   32'h0000_1234, '0);
        queue_request(OP_COUNT,    '0, '0);
        queue_request(OP_SPARE_LO, '1, '1);
        queue_request(OP_SPARE_HI, 32'h5A5A_A5A5, 48'hA5A5_5A5A_A5A5);
        queue_request(OP_INSERT,   '0, '0);
        queue_request(OP_INSERT,   '1, '1);
        queue_request(OP_INSERT,   '0, 48'h77);
        queue_request(OP_INSERT,   32'h0000_00A1, 48'h100);
        queue_request(OP_INSERT,   32'h0000_00B2, 48'h100);
        queue_request(OP_INSERT,   32'h0000_00C3, 48'h100);
        queue_request(OP_TOUCH,    32'h0000_00A1, 48'h100);
        queue_request(OP_TOUCH,    32'h0000_00B2, 48'h200);
        queue_request(OP_TOUCH,    32'h0000_00B2, 48'h100);
        queue_request(OP_LOOKUP,   '1, '0);
        queue_request(OP_COUNT,    '0, '1);
        queue_request(OP_EVICT,    '0, '0);
        queue_request(OP_EVICT,    '0, '0);
        queue_request(OP_REMOVE,   32'h0000_00C3, '0);
        queue_request(OP_EVICT,    '0, '0);
        queue_request(OP_EVICT,    '0, '0);
        queue_request(OP_EVICT,    '0, '0);

        page_pool[0] = '0;
        page_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++)
            page_pool[i] = $urandom;

        // Random part in phases that fill, churn and drain the table. Inserts
        // in a filling phase mostly walk the pool in order so that the table
        // reaches full; other pages come from the pool so that most requests
        // find their page, with a few random pages that are most likely absent.
        made       = 0;
        phase_no   = 0;
        phase_left = 0;
        phase_kind = 0;
        walk_idx   = 0;
        clock_now  = 48'h1000;
        while (made < RAND_ITEMS)
        begin
            settle = 1'b0;
            if (phase_left == 0)
            begin
                phase_kind = phase_no % 4;
                phase_left = (phase_kind == 0) ? $urandom_range(70, 110) : $urandom_range(40, 80);
                // Wait for a quiet block after the directed part and once mid-run.
                settle = (phase_no == 0 || phase_no == 6);
                phase_no++;
            end
            pick = $urandom_range(0, 99);
            case (phase_kind)
                0:       op = (pick < 80) ? OP_INSERT : (pick < 86) ? OP_TOUCH :
                              (pick < 92) ? OP_LOOKUP : (pick < 95) ? OP_REMOVE :
                              (pick < 97) ? OP_EVICT : (pick < 99) ? OP_COUNT : OP_SPARE_LO;
                2:       op = (pick < 15) ? OP_INSERT : (pick < 25) ? OP_TOUCH :
                              (pick < 35) ? OP_LOOKUP : (pick < 55) ? OP_REMOVE :
                              (pick < 90) ? OP_EVICT : (pick < 96) ? OP_COUNT : OP_SPARE_HI;
                default: op = (pick < 35) ? OP_INSERT : (pick < 55) ? OP_TOUCH :
                              (pick < 70) ? OP_LOOKUP : (pick < 80) ? OP_REMOVE :
                              (pick < 92) ? OP_EVICT : (pick < 97) ? OP_COUNT :
                              pick[0] ? OP_SPARE_HI : OP_SPARE_LO;
            endcase

            pick = $urandom_range(0, 99);
            if (op == OP_INSERT && phase_kind == 0 && pick < 70)
            begin
                pg       = page_pool[walk_idx];
                walk_idx = (walk_idx + 1) % POOL_SIZE;
            end
            else if (pick < 90)
                pg = page_pool[$urandom_range(0, POOL_SIZE - 1)];
            else
                pg = $urandom;

            // Small times give plenty of ties; others are random over the whole field, a rising clock or all ones.
            pick = $urandom_range(0, 99);
            if (pick < 40)
                ts = TIME_W'($urandom_range(0, 7));
            else if (pick < 70)
                ts = TIME_W'({$urandom, $urandom});
            else if (pick < 95)
            begin
                clock_now = clock_now + TIME_W'($urandom_range(0, 3));
                ts        = clock_now;
            end
            else
                ts = '1;

            queue_request(op, pg, ts, settle);
            made++;
            phase_left--;
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(posedge clk);
        while (pending_reqs.size() > 0 || s_tvalid || replies_due.size() > 0);

        // Let any stray result surface before the verdict.
        repeat (TAIL_WAIT) @(posedge clk);
        if (mismatches == 0 && replies_due.size() == 0)
            $display("lru_page_tracker_table_test: PASS");
        else
            $display("lru_page_tracker_table_test: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Request driver: bursts of random length separated by random gaps. A
    // request marked to settle is held back until every result has arrived.
    // ------------------------------------------------------------------------
    int burst_left = 1;
    int gap_left   = 0;

    always @(posedge clk)
    begin
        logic offer;
        offer = s_tvalid;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                replies_due.insert(replies_due.size(), track_page_op(req_on_bus));
                offer = 1'b0;
            end
            if (!offer)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pending_reqs.size() > 0 &&
                         (!pending_reqs[0].settle || replies_due.size() == 0))
                begin
                    req_on_bus = pending_reqs.pop_front();
                    offer      = 1'b1;
                    s_tdata   <= {5'b0, req_on_bus.stamp, req_on_bus.page, req_on_bus.opcode};
                    burst_left--;
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 12);
                        // Roughly half the bursts run straight on with no gap.
                        gap_left   = ($urandom_range(0, 1) == 0) ? 0 :
                                     ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) :
                                     $urandom_range(1, 6);
                    end
                end
            end
            s_tvalid <= offer;
        end
    end

    // ------------------------------------------------------------------------
    // Result receiver: its own stall pattern, one of four picked at random,
    // and one long hold-off while requests are on offer so that the block
    // fills up and stops taking requests.
    // ------------------------------------------------------------------------
    int  rx_cycle  = 0;
    int  rx_mode   = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            rx_cycle++;
            if (!hold_done && rx_cycle >= HOLD_START && s_tvalid)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_LEN;
            end
            if (rx_cycle % 400 == 0)
                rx_mode = $urandom_range(0, 3);
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                case (rx_mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(0, 2) != 0);
                    2:       m_tready <= (rx_cycle % 4 == 0);
                    default: m_tready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        page_reply_t got;
        page_reply_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.status = m_tdata[2:0];
            got.page   = m_tdata[34:3];
            got.stamp  = m_tdata[82:35];
            got.count  = m_tdata[89:83];
            if (replies_due.size() == 0)
            begin
                mismatches++;
                $display("%0t: result with no request outstanding, expected none, got %h",
                         $time, m_tdata);
            end
            else
            begin
                want = replies_due.pop_front();
                if (got.status != want.status)
                begin
                    mismatches++;
                    $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
                end
                if (got.page != want.page)
                begin
                    mismatches++;
                    $display("%0t: result_page expected %h got %h", $time, want.page, got.page);
                end
                if (got.stamp != want.stamp)
                begin
                    mismatches++;
                    $display("%0t: result_time expected %h got %h", $time, want.stamp, got.stamp);
                end
                if (got.count != want.count)
                begin
                    mismatches++;
                    $display("%0t: entry_count expected %0d got %0d", $time, want.count, got.count);
                end
            end
        end
    end

    // Watchdog: ends a run that never finishes and reports it as a failure.
    int cycle_count = 0;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP)
        begin
            $display("lru_page_tracker_table_test: FAIL");
            $finish;
        end
    end

endmodule

### files.f
sv/lrut_pkg.sv
sv/lrut_ram.sv
sv/lrut_scan.sv
sv/lrut_ctrl.sv
sv/lru_page_tracker_table.sv
tb/lru_page_tracker_table_test.sv
